/* rtl/integer_literal_to_binary_assert.svh */
// Assertion macros for the integer literal parser.
// Expanded inside modules that declare clk and rst_n.
`ifndef INTEGER_LITERAL_TO_BINARY_ASSERT_SVH
`define INTEGER_LITERAL_TO_BINARY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ILB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ILB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ilb_pkg.sv */
// Shared types, constants and helpers for the integer literal parser.
// No dependencies.
`default_nettype none

package ilb_pkg;

  typedef enum logic [1:0] {
    SEL_DEC = 2'd0,
    SEL_BIN = 2'd1,
    SEL_OCT = 2'd2,
    SEL_HEX = 2'd3
  } radix_sel_t;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned EXT_W  = VAL_W + 4;  // room for acc * 16
  localparam int unsigned DIG_W  = 6;          // digit values 0..35
  localparam int unsigned RAD_W  = 5;          // radix up to 16
  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [1:0]        POS_MAX   = 2'd2;

  // running parse state of one literal
  typedef struct packed {
    logic [VAL_W-1:0] acc;
    radix_sel_t       sel;
    logic [1:0]       pos;
    logic             lz;
    logic             err;
    logic             nd;
  } parse_state_t;

  // decoded character
  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             is_digit;
    logic             is_zero;
    radix_sel_t       pfx;
  } char_info_t;

  localparam parse_state_t STATE_CLEAR = '{
    acc: '0, sel: SEL_DEC, pos: 2'd0, lz: 1'b0, err: 1'b0, nd: 1'b0
  };

  function automatic logic [RAD_W-1:0] radix_of(radix_sel_t s);
    logic [RAD_W-1:0] r;
    case (s)
      SEL_BIN: r = 5'd2;
      SEL_OCT: r = 5'd8;
      SEL_HEX: r = 5'd16;
      default: r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ilb_ifs.sv */
// Valid/ready channel interfaces for the integer literal parser.
// Depends on ilb_pkg for field widths.
`default_nettype none

interface ilb_in_if;
  logic                              valid;
  logic                              ready;
  logic [ilb_pkg::CHAR_W-1:0]        char_code;
  logic                              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ilb_out_if;
  logic                              valid;
  logic                              ready;
  logic [ilb_pkg::VAL_W-1:0]         value;
  logic                              ok;

  modport source (output valid, output value, output ok, input ready);
  modport sink   (input valid, input value, input ok, output ready);
endinterface

`default_nettype wire

/* rtl/ilb_decode.sv */
// Character classifier: digit value, digit flag, zero flag and prefix letter.
// Depends on ilb_pkg.
`default_nettype none

module ilb_decode (
  input  wire logic [ilb_pkg::CHAR_W-1:0] char_code,
  output ilb_pkg::char_info_t             info
);

  always_comb begin
    info          = '0;
    info.pfx      = ilb_pkg::SEL_DEC;
    info.is_zero  = (char_code == ilb_pkg::CHAR_ZERO);
    case (char_code) inside
      [8'h30:8'h39]: begin
        info.digit    = ilb_pkg::DIG_W'(char_code - 8'h30);
        info.is_digit = 1'b1;
      end
      [8'h61:8'h7A]: begin
        info.digit    = ilb_pkg::DIG_W'(char_code - 8'h57);  // 'a' -> 10
        info.is_digit = 1'b1;
      end
      [8'h41:8'h5A]: begin
        info.digit    = ilb_pkg::DIG_W'(char_code - 8'h37);  // 'A' -> 10
        info.is_digit = 1'b1;
      end
      default: begin
        info.is_digit = 1'b0;
      end
    endcase

    case (char_code) inside
      8'h62, 8'h42: info.pfx = ilb_pkg::SEL_BIN;
      8'h6F, 8'h4F: info.pfx = ilb_pkg::SEL_OCT;
      8'h78, 8'h58: info.pfx = ilb_pkg::SEL_HEX;
      default:      info.pfx = ilb_pkg::SEL_DEC;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ilb_step.sv */
// One-character update of the parse state: prefix capture, digit check,
// shift-add multiply by the radix with 64-bit overflow check. Depends on ilb_pkg.
`default_nettype none

module ilb_step (
  input  wire ilb_pkg::parse_state_t       cur,
  input  wire ilb_pkg::char_info_t         info,
  input  wire logic                        last_char,
  output ilb_pkg::parse_state_t            nxt,
  output logic [ilb_pkg::VAL_W-1:0]        res_value,
  output logic                             res_ok
);

  ilb_pkg::parse_state_t        upd;
  logic [ilb_pkg::EXT_W-1:0]    acc_x;
  logic [ilb_pkg::EXT_W-1:0]    scaled;
  logic [ilb_pkg::EXT_W-1:0]    sum;
  logic                         take_pfx;
  logic                         too_big;

  always_comb begin
    acc_x = {4'b0, cur.acc};
    case (cur.sel)
      ilb_pkg::SEL_BIN: scaled = acc_x << 1;
      ilb_pkg::SEL_OCT: scaled = acc_x << 3;
      ilb_pkg::SEL_HEX: scaled = acc_x << 4;
      default:          scaled = (acc_x << 3) + (acc_x << 1);  // x10
    endcase
    sum = scaled + {{(ilb_pkg::EXT_W - ilb_pkg::DIG_W){1'b0}}, info.digit};
  end

  // prefix letter only counts as second char after a leading zero
  assign take_pfx = (cur.pos == 2'd1) && cur.lz && (info.pfx != ilb_pkg::SEL_DEC);
  assign too_big  = !info.is_digit || (info.digit >= {1'b0, ilb_pkg::radix_of(cur.sel)});

  always_comb begin
    upd = cur;
    if (!cur.err) begin
      if (take_pfx) begin
        upd.sel = info.pfx;
        upd.acc = '0;
        upd.nd  = 1'b1;
      end else begin
        if ((cur.pos == 2'd0) && info.is_zero) begin
          upd.lz = 1'b1;
        end
        if (too_big) begin
          upd.err = 1'b1;
        end else if (sum[ilb_pkg::EXT_W-1:ilb_pkg::VAL_W] != 4'd0) begin
          upd.err = 1'b1;  // overflow past 2^64-1
        end else begin
          upd.acc = sum[ilb_pkg::VAL_W-1:0];
          upd.nd  = 1'b0;
        end
      end
    end
    if (cur.pos != ilb_pkg::POS_MAX) begin
      upd.pos = cur.pos + 2'd1;
    end

    res_ok    = !upd.err && !upd.nd;
    res_value = res_ok ? upd.acc : '0;
    nxt       = last_char ? ilb_pkg::STATE_CLEAR : upd;
  end

endmodule

`default_nettype wire

/* rtl/integer_literal_to_binary.sv */
// Top level of the streaming integer literal parser.
// Depends on ilb_pkg, ilb_ifs, ilb_decode, ilb_step and the assertion header.
// ---------------------------------------------------------------------------
// Usage:
//   in_word  : one ASCII character per word plus last_char marking the end
//              of the literal. Optional 0b/0o/0x prefix (either case) picks
//              radix 2/8/16, otherwise radix 10.
//   out_word : one word per literal, issued for the last character only:
//              value (64-bit) and ok. value is 0 when ok is low.
// Path: a last character is loaded into the input register, then the state
//   update writes its word into the result register, which drives out_word.
// Throughput: one character per cycle unless a last character stalls. The
//   per-character work is a shift-add multiply by the radix plus a 68-bit
//   overflow check, combinational between input and state/result registers.
// Stall: if the result register holds an untaken word, a pending last
//   character waits in the input register; in_word.ready drops only then.
//   Non-final characters keep flowing since they produce no word.
// Reset: synchronous, active low. Clears the parse state and both valid
//   flags; the next character starts a fresh literal.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_literal_to_binary_assert.svh"

module integer_literal_to_binary (
  input  wire logic clk,
  input  wire logic rst_n,
  ilb_in_if.sink    in_word,
  ilb_out_if.source out_word
);

  // input register
  logic                             in_v_r;
  logic [ilb_pkg::CHAR_W-1:0]       in_char_r;
  logic                             in_last_r;

  // parse state
  ilb_pkg::parse_state_t            st_r;
  ilb_pkg::parse_state_t            st_nxt;

  // result register
  logic                             out_v_r;
  logic [ilb_pkg::VAL_W-1:0]        out_val_r;
  logic                             out_ok_r;

  ilb_pkg::char_info_t              info;
  logic [ilb_pkg::VAL_W-1:0]        res_value;
  logic                             res_ok;
  logic                             adv;
  logic                             in_take;

  // a staged char moves on unless it would emit into a full, untaken result register
  assign adv     = in_v_r && (!in_last_r || !out_v_r || out_word.ready);
  assign in_word.ready = !in_v_r || adv;
  assign in_take = in_word.valid && in_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_word.ready) begin
      in_v_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_word.char_code;
      in_last_r <= in_word.last_char;
    end
  end

  ilb_decode u_decode (
    .char_code (in_char_r),
    .info      (info)
  );

  ilb_step u_step (
    .cur       (st_r),
    .info      (info),
    .last_char (in_last_r),
    .nxt       (st_nxt),
    .res_value (res_value),
    .res_ok    (res_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ilb_pkg::STATE_CLEAR;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_word.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_val_r <= res_value;
      out_ok_r  <= res_ok;
    end
  end

  assign out_word.valid = out_v_r;
  assign out_word.value = out_val_r;
  assign out_word.ok    = out_ok_r;

  // failed literals report zero
  `ILB_ASSERT_SAME(a_fail_zero, out_v_r && !out_ok_r, out_val_r == '0, "failed literal with nonzero value")
  // state is fresh after the last character of a literal
  `ILB_ASSERT_NEXT(a_clear_after_last, adv && in_last_r, (st_r.acc == '0) && (st_r.pos == 2'd0) && !st_r.err && !st_r.nd && !st_r.lz && (st_r.sel == ilb_pkg::SEL_DEC), "state not cleared after literal")
  // error is sticky inside a literal
  `ILB_ASSERT_NEXT(a_err_sticky, st_r.err && !(adv && in_last_r), st_r.err, "error flag dropped mid literal")
  // a pending prefix always has a non-decimal radix
  `ILB_ASSERT_SAME(a_prefix_radix, st_r.nd, st_r.sel != ilb_pkg::SEL_DEC, "prefix pending with decimal radix")

endmodule

`default_nettype wire
